/* design/twicr_pkg.sv */
// Shared types, codes and microcode program for the frame checksum receiver.
`default_nettype none

package twicr_pkg;

    typedef logic [7:0] byte_t;

    // Request op codes
    localparam logic [1:0] OP_ADDR = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Configuration register indexes
    localparam logic CFG_LINK_RELOAD  = 1'b0;
    localparam logic CFG_ERROR_RELOAD = 1'b1;

    // Reset values of the reload registers
    localparam byte_t LINK_RELOAD_RST  = 8'd20;
    localparam byte_t ERROR_RELOAD_RST = 8'd100;

    // Sequencer step addresses
    localparam int unsigned STEP_W = 2;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_FETCH = 2'd0;
    localparam step_t STEP_SUM   = 2'd1;
    localparam step_t STEP_CMP   = 2'd2;
    localparam step_t STEP_EMIT  = 2'd3;

    // Datapath actions
    typedef logic [1:0] act_t;
    localparam act_t ACT_FETCH = 2'd0;
    localparam act_t ACT_SUM   = 2'd1;
    localparam act_t ACT_CMP   = 2'd2;
    localparam act_t ACT_EMIT  = 2'd3;

    // Jump conditions
    typedef logic [1:0] cond_t;
    localparam cond_t COND_CHECKSUM = 2'd0;  // data byte lands at position 0
    localparam cond_t COND_IDX_END  = 2'd1;  // index reached last payload byte
    localparam cond_t COND_MATCH    = 2'd2;  // sum equals checksum byte

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t jmp;   // next step when the condition holds
        step_t nxt;   // next step otherwise
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        case (step)
            STEP_FETCH: w = '{act: ACT_FETCH, cond: COND_CHECKSUM,
                              jmp: STEP_SUM,  nxt: STEP_FETCH};
            STEP_SUM:   w = '{act: ACT_SUM,   cond: COND_IDX_END,
                              jmp: STEP_CMP,  nxt: STEP_SUM};
            STEP_CMP:   w = '{act: ACT_CMP,   cond: COND_MATCH,
                              jmp: STEP_EMIT, nxt: STEP_FETCH};
            STEP_EMIT:  w = '{act: ACT_EMIT,  cond: COND_IDX_END,
                              jmp: STEP_FETCH, nxt: STEP_EMIT};
            default:    w = '{act: ACT_FETCH, cond: COND_CHECKSUM,
                              jmp: STEP_FETCH, nxt: STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* design/twi_slave_frame_checksum_receiver_core.sv */
// Top level: slave frame receiver with additive checksum and link watchdog.
// Results: a status result is valid in the cycle after its request is taken; a checksum
//   byte is summed over the payload in SUM, then compared in CMP, which loads a bad result.
// Throughput: 1 request per cycle for status requests while the result slot is free; a good
//   frame holds the sequencer for serial sum, compare, then one result per cycle as taken.
// Reset: aresetn sync active low; clears buffer, position, flag; loads default reloads.
`default_nettype none

module twi_slave_frame_checksum_receiver_core
    import twicr_pkg::*;
#(
    parameter int unsigned FRAME_PAYLOAD = 10   // payload bytes per frame, 1..15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata,

    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [7:0]  s_data,

    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_byte_index,
    output logic [7:0]       m_byte_value,
    output logic             m_last,
    output logic             m_frame_ok,
    output logic             m_frame_bad,
    output logic             m_link_timeout,
    output logic             m_no_link
);

    // Index covers positions 0..FRAME_PAYLOAD of the frame buffer.
    localparam int unsigned IDX_W = $clog2(FRAME_PAYLOAD + 1);
    localparam int unsigned DEPTH = FRAME_PAYLOAD + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_PAYLOAD);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    byte_t            link_reload_reg, error_reload_reg;
    byte_t            link_cnt_reg, link_cnt_next;
    byte_t            err_cnt_reg, err_cnt_next;
    logic             no_link_reg, no_link_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    byte_t            sum_reg, sum_next;
    step_t            step_reg, step_next;
    byte_t            buf_reg [DEPTH];

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [3:0]       out_index_reg;
    byte_t            out_value_reg;
    logic             out_last_reg, out_ok_reg, out_bad_reg;
    logic             out_timeout_reg, out_nolink_reg;

    // ------------------------------------------------------------------
    // Sequencer control
    // ------------------------------------------------------------------
    ucode_t           ctrl;
    logic             slot_free;   // output register empty or draining
    logic             go;          // current step completes this cycle
    logic             cond_true;
    logic             buf_wr_en;
    byte_t            buf_rd;      // buffer byte at the loop index
    logic             out_load;
    logic [3:0]       out_index;
    byte_t            out_value;
    logic             out_last, out_ok, out_bad;

    assign ctrl      = ucode_rom(step_reg);
    assign slot_free = !m_valid_reg || m_ready;
    assign buf_rd    = buf_reg[idx_reg];
    assign s_ready   = (ctrl.act == ACT_FETCH) && slot_free;

    // jump condition selected by the control word
    always_comb begin
        case (ctrl.cond)
            COND_CHECKSUM: cond_true = (s_op == OP_DATA) && (pos_reg == '0);
            COND_IDX_END:  cond_true = (idx_reg == IDX_LAST);
            COND_MATCH:    cond_true = (sum_reg == buf_reg[0]);
            default:       cond_true = 1'b0;
        endcase
    end

    // datapath actions
    always_comb begin
        go            = 1'b0;
        buf_wr_en     = 1'b0;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        link_cnt_next = link_cnt_reg;
        err_cnt_next  = err_cnt_reg;
        no_link_next  = no_link_reg;
        out_load      = 1'b0;
        out_index     = 4'd0;
        out_value     = 8'd0;
        out_last      = 1'b1;
        out_ok        = 1'b0;
        out_bad       = 1'b0;

        case (ctrl.act)
            ACT_FETCH: begin
                go = s_valid && slot_free;
                if (go) begin
                    idx_next = IDX_ONE;
                    sum_next = 8'd0;
                    case (s_op)
                        OP_ADDR: begin
                            pos_next = IDX_LAST;
                            out_load = 1'b1;
                        end
                        OP_DATA: begin
                            buf_wr_en = 1'b1;
                            if (pos_reg != '0) begin
                                pos_next = pos_reg - IDX_ONE;
                                out_load = 1'b1;
                            end
                        end
                        OP_TICK: begin
                            if (link_cnt_reg != 8'd0) begin
                                link_cnt_next = link_cnt_reg - 8'd1;
                            end
                            if (err_cnt_reg != 8'd0) begin
                                err_cnt_next = err_cnt_reg - 8'd1;
                            end else begin
                                no_link_next = 1'b1;
                            end
                            out_load = 1'b1;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ACT_SUM: begin
                go       = 1'b1;
                sum_next = sum_reg + buf_rd;
                idx_next = idx_reg + IDX_ONE;
            end
            ACT_CMP: begin
                go = slot_free;
                if (go) begin
                    idx_next = IDX_ONE;
                    if (cond_true) begin
                        link_cnt_next = link_reload_reg;
                        err_cnt_next  = error_reload_reg;
                    end else begin
                        out_load = 1'b1;
                        out_bad  = 1'b1;
                    end
                end
            end
            ACT_EMIT: begin
                go = slot_free;
                if (go) begin
                    out_load  = 1'b1;
                    out_index = 4'(idx_reg);
                    out_value = buf_rd;
                    out_last  = cond_true;
                    out_ok    = 1'b1;
                    idx_next  = idx_reg + IDX_ONE;
                end
            end
            default: begin
                go = 1'b0;
            end
        endcase

        step_next = go ? (cond_true ? ctrl.jmp : ctrl.nxt) : step_reg;
    end

    // result valid: set on load, cleared when taken
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reload_reg  <= LINK_RELOAD_RST;
            error_reload_reg <= ERROR_RELOAD_RST;
            link_cnt_reg     <= LINK_RELOAD_RST;
            err_cnt_reg      <= ERROR_RELOAD_RST;
            no_link_reg      <= 1'b0;
            pos_reg          <= '0;
            idx_reg          <= '0;
            sum_reg          <= 8'd0;
            step_reg         <= STEP_FETCH;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LINK_RELOAD:  link_reload_reg  <= cfg_wdata;
                    CFG_ERROR_RELOAD: error_reload_reg <= cfg_wdata;
                    default:          link_reload_reg  <= link_reload_reg;
                endcase
            end
            link_cnt_reg <= link_cnt_next;
            err_cnt_reg  <= err_cnt_next;
            no_link_reg  <= no_link_next;
            pos_reg      <= pos_next;
            idx_reg      <= idx_next;
            sum_reg      <= sum_next;
            step_reg     <= step_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Frame buffer: reset to zero since a checksum may arrive before any address.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                buf_reg[i] <= 8'd0;
            end
        end else if (buf_wr_en) begin
            buf_reg[pos_reg] <= s_data;
        end
    end

    // Result payload; status bits show counter state after this request.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_index_reg   <= out_index;
            out_value_reg   <= out_value;
            out_last_reg    <= out_last;
            out_ok_reg      <= out_ok;
            out_bad_reg     <= out_bad;
            out_timeout_reg <= (link_cnt_next == 8'd0);
            out_nolink_reg  <= no_link_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_byte_index   = out_index_reg;
    assign m_byte_value   = out_value_reg;
    assign m_last         = out_last_reg;
    assign m_frame_ok     = out_ok_reg;
    assign m_frame_bad    = out_bad_reg;
    assign m_link_timeout = out_timeout_reg;
    assign m_no_link      = out_nolink_reg;

endmodule

`default_nettype wire

/* sim/twi_slave_frame_checksum_receiver_core_tb.sv */
`timescale 1ns / 1ps
// Testbench for the frame checksum receiver core, with a request-level predictor.
module twi_slave_frame_checksum_receiver_core_tb;
    import twicr_pkg::*;

    localparam int unsigned PAYLOAD     = 10;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;    // undecoded op, must still give a status result

    typedef logic [PAYLOAD*8-1:0] payload_t;

    // One result beat, fields in port order
    typedef struct packed {
        logic [3:0] byte_index;
        byte_t      byte_value;
        logic       last;
        logic       frame_ok;
        logic       frame_bad;
        logic       link_timeout;
        logic       no_link;
    } frame_result_t;

    // Clock, reset and block inputs, all known from time zero
    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_index = CFG_LINK_RELOAD;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_valid   = 1'b0;
    logic [1:0] s_op      = OP_ADDR;
    logic [7:0] s_data    = 8'd0;
    logic       m_ready   = 1'b0;

    logic       s_ready;
    logic       m_valid;
    logic [3:0] m_byte_index;
    logic [7:0] m_byte_value;
    logic       m_last;
    logic       m_frame_ok;
    logic       m_frame_bad;
    logic       m_link_timeout;
    logic       m_no_link;

    // Predictor copy of the receiver state
    logic [3:0] rx_pos;
    byte_t      rx_frame [0:PAYLOAD];
    byte_t      rx_held  [0:PAYLOAD-1];
    byte_t      link_cnt;
    byte_t      err_cnt;
    byte_t      link_reload;
    byte_t      err_reload;
    logic       no_link_set;

    frame_result_t pending_results[$];

    // Run bookkeeping
    int unsigned tx_idle_pct   = 13;
    int unsigned rx_idle_pct   = 47;
    int unsigned requests_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned frames_good   = 0;
    int unsigned frames_bad    = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;

    twi_slave_frame_checksum_receiver_core #(
        .FRAME_PAYLOAD (PAYLOAD)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_index   (m_byte_index),
        .m_byte_value   (m_byte_value),
        .m_last         (m_last),
        .m_frame_ok     (m_frame_ok),
        .m_frame_bad    (m_frame_bad),
        .m_link_timeout (m_link_timeout),
        .m_no_link      (m_no_link)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver back-pressure; a zero percentage keeps ready high
    always @(posedge aclk) begin
        m_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    // Outputs only move at the rising edge, so the falling edge sees exactly
    // what the next rising edge will take.
    always @(negedge aclk) begin : check_results
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_byte_index, m_byte_value, m_last, m_frame_ok, m_frame_bad,
                   m_link_timeout, m_no_link};
            results_seen++;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: expected no result, got idx %0d val %02h last %b ok %b",
                         $time, got.byte_index, got.byte_value, got.last, got.frame_ok);
                $display("    bad %b to %b nl %b",
                         got.frame_bad, got.link_timeout, got.no_link);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: expected idx %0d val %02h last %b ok %b bad %b to %b nl %b",
                             $time, want.byte_index, want.byte_value, want.last,
                             want.frame_ok, want.frame_bad, want.link_timeout, want.no_link);
                    $display("    got idx %0d val %02h last %b ok %b bad %b to %b nl %b",
                             got.byte_index, got.byte_value, got.last, got.frame_ok,
                             got.frame_bad, got.link_timeout, got.no_link);
                end
            end
        end
    end

    // Works out the results one request causes and queues them.
    task automatic predict_frame_results(input logic [1:0] op, input byte_t data);
        int unsigned   pos;
        byte_t         sum;
        logic          good;
        logic          bad;
        frame_result_t r;
        good = 1'b0;
        bad  = 1'b0;
        case (op)
            OP_ADDR: rx_pos = 4'(PAYLOAD);
            OP_DATA: begin
                pos = (rx_pos > PAYLOAD) ? PAYLOAD : 32'(rx_pos);
                rx_frame[pos] = data;
                if (pos != 0) begin
                    rx_pos = 4'(pos - 1);
                end else begin
                    // position 0 holds the checksum; compare with the payload sum
                    sum = 8'd0;
                    for (int i = 1; i <= PAYLOAD; i++)
                        sum += rx_frame[i];
                    if (sum == rx_frame[0]) begin
                        for (int i = 0; i < PAYLOAD; i++)
                            rx_held[i] = rx_frame[i + 1];
                        link_cnt = link_reload;
                        err_cnt  = err_reload;
                        good     = 1'b1;
                        frames_good++;
                    end else begin
                        bad = 1'b1;
                        frames_bad++;
                    end
                end
            end
            OP_TICK: begin
                if (link_cnt != 0)
                    link_cnt--;
                if (err_cnt != 0)
                    err_cnt--;
                else
                    no_link_set = 1'b1;    // sticky until reset
            end
            default: ;
        endcase
        r.link_timeout = (link_cnt == 8'd0);
        r.no_link      = no_link_set;
        if (good) begin
            // a good frame comes back as its payload, index 1 first
            for (int i = 0; i < PAYLOAD; i++) begin
                r.byte_index = 4'(i + 1);
                r.byte_value = rx_held[i];
                r.last       = (i == PAYLOAD - 1);
                r.frame_ok   = 1'b1;
                r.frame_bad  = 1'b0;
                pending_results.push_back(r);
            end
        end else begin
            r.byte_index = 4'd0;
            r.byte_value = 8'd0;
            r.last       = 1'b1;
            r.frame_ok   = 1'b0;
            r.frame_bad  = bad;
            pending_results.push_back(r);
        end
    endtask

    // Entered and left at a rising edge. Valid is lowered only for a sender gap
    // and stays high across back-to-back requests.
    task automatic send_request(input logic [1:0] op, input byte_t data);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_data  <= data;
        do @(negedge aclk); while (!s_ready);
        predict_frame_results(op, data);
        @(posedge aclk);
        requests_sent++;
    endtask

    // Address, payload (first byte lands at the top position), then checksum.
    task automatic send_frame(input payload_t payload, input bit corrupt);
        byte_t sum;
        sum = 8'd0;
        send_request(OP_ADDR, byte_t'($urandom));
        for (int i = 0; i < PAYLOAD; i++) begin
            sum += payload[i*8 +: 8];
            send_request(OP_DATA, payload[i*8 +: 8]);
        end
        if (corrupt)
            sum ^= byte_t'($urandom_range(1, 255));
        send_request(OP_DATA, sum);
    endtask

    // Stop sending and let every queued result drain; the block is idle after.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes both reload registers; only called while idle.
    task automatic load_reloads(input byte_t link_val, input byte_t err_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LINK_RELOAD;
        cfg_wdata <= link_val;
        @(posedge aclk);
        cfg_index <= CFG_ERROR_RELOAD;
        cfg_wdata <= err_val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        link_reload = link_val;
        err_reload  = err_val;
        @(posedge aclk);
    endtask

    task automatic reset_block();
        rx_pos      = 4'd0;
        link_reload = LINK_RELOAD_RST;
        err_reload  = ERROR_RELOAD_RST;
        link_cnt    = LINK_RELOAD_RST;
        err_cnt     = ERROR_RELOAD_RST;
        no_link_set = 1'b0;
        for (int i = 0; i <= PAYLOAD; i++)
            rx_frame[i] = 8'd0;
        for (int i = 0; i < PAYLOAD; i++)
            rx_held[i] = 8'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    endtask

    // Position is 0 after reset, so a lone byte is a checksum over the cleared
    // buffer: a nonzero byte fails, a zero byte passes and commits all zeros.
    task automatic test_data_before_address();
        send_request(OP_DATA, 8'h5a);
        send_request(OP_DATA, 8'h00);
    endtask

    // Payload at the byte extremes, correct checksum
    task automatic test_good_frame();
        send_frame({8'hff, 8'haa, 8'h55, 8'hfe, 8'h01, 8'h7f, 8'h80, 8'hff, 8'h00, 8'hff}, 1'b0);
    endtask

    // Bytes past the checksum keep overwriting position 0 and are rechecked.
    // The reloads are changed first so the good recheck loads the new values.
    task automatic test_checksum_overrun();
        byte_t sum;
        sum = 8'd0;
        for (int i = 1; i <= PAYLOAD; i++)
            sum += rx_frame[i];
        send_request(OP_DATA, ~sum);
        wait_idle();
        load_reloads(8'd0, 8'd255);
        send_request(OP_DATA, sum);
    endtask

    // Ticks with data that must be ignored, address with data, undecoded op
    task automatic test_tick_and_unused_op();
        send_request(OP_TICK, 8'hff);
        send_request(OP_TICK, 8'h00);
        send_request(OP_UNUSED, 8'hff);
        send_request(OP_UNUSED, 8'h00);
        send_request(OP_ADDR, 8'hff);
        send_request(OP_ADDR, 8'h00);
    endtask

    // Mostly whole frames with random content and some bad checksums, mixed
    // with tick bursts, cut-off frames, stray bytes and undecoded ops.
    task automatic test_random_frames(input int unsigned tx_pct, input int unsigned rx_pct,
                                      input byte_t link_val, input byte_t err_val,
                                      input int unsigned count);
        int unsigned target;
        int unsigned pick;
        wait_idle();
        load_reloads(link_val, err_val);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target      = requests_sent + count;
        while (requests_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_frame(payload_t'({$urandom, $urandom, $urandom}),
                           $urandom_range(99) < 25);
            end else if (pick < 78) begin
                repeat ($urandom_range(1, 5))
                    send_request(OP_TICK, byte_t'($urandom));
            end else if (pick < 86) begin
                // frame cut short; the next address restarts the count
                send_request(OP_ADDR, byte_t'($urandom));
                repeat ($urandom_range(1, PAYLOAD - 1))
                    send_request(OP_DATA, byte_t'($urandom));
            end else if (pick < 94) begin
                send_request(OP_DATA, byte_t'($urandom));
            end else begin
                send_request(OP_UNUSED, byte_t'($urandom));
            end
        end
    endtask

    initial begin
        reset_block();
        test_data_before_address();
        test_good_frame();
        test_checksum_overrun();
        test_tick_and_unused_op();
        test_random_frames(13, 47, 8'd255, 8'd200, 35);
        test_random_frames(47, 13, 8'd3, 8'd0, 35);
        test_random_frames(0, 0, byte_t'($urandom), byte_t'($urandom_range(0, 8)), 30);
        wait_idle();
        repeat (30) @(posedge aclk);
        $display("%0d requests sent, %0d results checked, %0d failures",
                 requests_sent, results_seen, error_count);
        $display("%0d good and %0d bad frames, no-link flag ended at %b",
                 frames_good, frames_bad, no_link_set);
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
design/twicr_pkg.sv
design/twi_slave_frame_checksum_receiver_core.sv
sim/twi_slave_frame_checksum_receiver_core_tb.sv
